// ----- hw/rtl/random_cyclic_permutation_builder_core_assert.svh -----
// Assertion macros for the permutation builder core.
// Used by the top level only; depends on nothing.
`ifndef RANDOM_CYCLIC_PERMUTATION_BUILDER_CORE_ASSERT_SVH
`define RANDOM_CYCLIC_PERMUTATION_BUILDER_CORE_ASSERT_SVH
`define RCP_ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rcp assertion failed");
`define RCP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rcp assertion failed");
`endif

// ----- hw/rtl/rcp_pkg.sv -----
// Shared types and constants for the permutation builder.
// No dependencies.
package rcp_pkg;
	localparam int unsigned MaxNodes = 1024;
	localparam int unsigned NodeW = $clog2(MaxNodes);
	localparam int unsigned CountW = 11;
	localparam logic [63:0] Seed = 64'h9E3779B97F4A7C15;
	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StNotBuilt = 2'd1;
	localparam logic [1:0] StRange = 2'd2;
	localparam logic [1:0] StBuilt = 2'd3;
	localparam logic KindBuild = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_RNG, S_DIV, S_RDI, S_RDJ, S_WRI, S_WRJ,
		S_LRD0, S_LRD, S_LWR, S_LOOK, S_LOOK2, S_DONE
	} state_t;

	typedef struct packed {
		logic init_clr;
		logic init_wr;
		logic rng_load;
		logic rng_step;
		logic div_start;
		logic rd_i;
		logic rd_j;
		logic wr_i;
		logic wr_j;
		logic lk_rd0;
		logic lk_rd;
		logic lk_wr;
		logic look_rd;
		logic set_ready;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic shuf_last;
		logic div_done;
		logic link_last;
	} sts_t;
endpackage

// ----- hw/rtl/rcp_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module rcp_ram #(
	parameter int unsigned Width = 10,
	parameter int unsigned Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/rcp_mod.sv -----
// Restoring 64-by-10 bit modulo unit, one quotient bit per cycle.
// Depends on rcp_pkg.
module rcp_mod (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [rcp_pkg::NodeW-1:0] divisor,
	output logic done,
	output logic [rcp_pkg::NodeW-1:0] rem
);
	import rcp_pkg::*;
	logic [63:0] num_q;
	logic [NodeW:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [NodeW+1:0] trial;
	logic [NodeW+1:0] diff;
	assign trial = {rem_q, num_q[63]};
	assign diff = trial - {2'b0, divisor};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= diff[NodeW+1] ? trial[NodeW:0] : diff[NodeW:0];
		end
	end
	assign rem = rem_q[NodeW-1:0];
endmodule

// ----- hw/rtl/rcp_datapath.sv -----
// Datapath: order/next tables, xorshift generator, modulo unit, counters.
// Depends on rcp_pkg, rcp_ram and rcp_mod.
module rcp_datapath (
	input logic clk,
	input logic arst_n,
	input rcp_pkg::cmd_t cmd,
	input logic [rcp_pkg::NodeW:0] count,
	input logic [rcp_pkg::NodeW-1:0] node,
	output rcp_pkg::sts_t sts,
	output logic [rcp_pkg::NodeW-1:0] succ
);
	import rcp_pkg::*;
	logic [63:0] rng_q;
	logic [63:0] x1;
	logic [63:0] x2;
	logic [63:0] x3;
	logic [NodeW:0] i_q;
	logic [NodeW-1:0] j_q;
	logic [NodeW-1:0] vi_q;
	logic [NodeW-1:0] first_q;
	logic [NodeW-1:0] prev_q;
	logic o_we;
	logic [NodeW-1:0] o_wa;
	logic [NodeW-1:0] o_wd;
	logic [NodeW-1:0] o_ra;
	logic [NodeW-1:0] o_rd;
	logic n_we;
	logic [NodeW-1:0] n_wa;
	logic [NodeW-1:0] n_wd;
	logic [NodeW-1:0] mrem;
	logic mdone;

	assign x1 = rng_q ^ (rng_q << 13);
	assign x2 = x1 ^ (x1 >> 7);
	assign x3 = x2 ^ (x2 << 17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rng_q <= Seed;
		else if (cmd.rng_load) rng_q <= Seed;
		else if (cmd.rng_step) rng_q <= x3;
	end

	always_ff @(posedge clk) begin
		if (cmd.init_clr) i_q <= '0;
		else if (cmd.init_wr) begin
			if (i_q + 1'b1 == count) i_q <= count - 1'b1;
			else i_q <= i_q + 1'b1;
		end else if (cmd.wr_j) i_q <= i_q - 1'b1;
		else if (cmd.lk_rd0) i_q <= '0;
		else if (cmd.lk_rd || cmd.lk_wr) i_q <= i_q + 1'b1;
		if (mdone) j_q <= mrem;
		if (cmd.rd_j) vi_q <= o_rd;
		if (cmd.lk_rd) begin
			if (i_q == 1) first_q <= o_rd;
			prev_q <= o_rd;
		end
	end

	rcp_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(x3),
		.divisor(i_q[NodeW-1:0]), .done(mdone), .rem(mrem)
	);

	always_comb begin
		o_we = cmd.init_wr | cmd.wr_i | cmd.wr_j;
		o_wa = cmd.wr_j ? j_q : i_q[NodeW-1:0];
		o_wd = cmd.init_wr ? i_q[NodeW-1:0] : (cmd.wr_i ? o_rd : vi_q);
		o_ra = cmd.rd_i ? i_q[NodeW-1:0] : (cmd.rd_j ? j_q : i_q[NodeW-1:0]);
	end

	rcp_ram #(.Width(NodeW), .Depth(MaxNodes)) u_order (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
	);

	always_comb begin
		n_we = cmd.lk_wr | (cmd.lk_rd && i_q > (NodeW+1)'(1));
		n_wa = prev_q;
		n_wd = cmd.lk_wr ? first_q : o_rd;
		if (cmd.lk_rd && i_q == 0) n_we = 1'b0;
	end

	rcp_ram #(.Width(NodeW), .Depth(MaxNodes)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(node), .rdata(succ)
	);

	assign sts.init_last = (i_q + 1'b1 == count);
	assign sts.shuf_last = (i_q == '0);
	assign sts.div_done = mdone;
	assign sts.link_last = (i_q == count + 1'b1);
endmodule

// ----- hw/rtl/rcp_ctrl.sv -----
// Controller state machine for build and lookup requests.
// Depends on rcp_pkg.
module rcp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic kind,
	input logic in_range,
	input logic cfg_wr,
	input rcp_pkg::sts_t sts,
	output rcp_pkg::cmd_t cmd,
	output logic busy,
	output logic ready_tbl,
	output logic res_vld,
	output logic [1:0] res_st
);
	import rcp_pkg::*;
	state_t st_q, st_d;
	logic ready_q;
	logic [1:0] lst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ready_q <= 1'b0;
			lst_q <= StOk;
		end else begin
			st_q <= st_d;
			if (cmd.set_ready) ready_q <= 1'b1;
			else if (cfg_wr) ready_q <= 1'b0;
			if (go && kind != KindBuild)
				lst_q <= !ready_q ? StNotBuilt : (in_range ? StOk : StRange);
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (go) st_d = (kind == KindBuild) ? S_INIT : S_LOOK;
			S_INIT: if (sts.init_last) st_d = S_RNG;
			S_RNG: st_d = sts.shuf_last ? S_LRD0 : S_DIV;
			S_DIV: if (sts.div_done) st_d = S_RDI;
			S_RDI: st_d = S_RDJ;
			S_RDJ: st_d = S_WRI;
			S_WRI: st_d = S_WRJ;
			S_WRJ: st_d = S_RNG;
			S_LRD0: st_d = S_LRD;
			S_LRD: if (sts.link_last) st_d = S_LWR;
			S_LWR: st_d = S_DONE;
			S_DONE: st_d = S_IDLE;
			S_LOOK: st_d = S_LOOK2;
			S_LOOK2: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (st_q != S_IDLE);
		res_vld = 1'b0;
		res_st = lst_q;
		case (st_q)
			S_IDLE: begin
				cmd.init_clr = go && kind == KindBuild;
				cmd.rng_load = go && kind == KindBuild;
			end
			S_INIT: cmd.init_wr = 1'b1;
			S_RNG: begin
				cmd.rng_step = !sts.shuf_last;
				cmd.div_start = !sts.shuf_last;
				cmd.lk_rd0 = sts.shuf_last;
			end
			S_RDI: cmd.rd_i = 1'b1;
			S_RDJ: cmd.rd_j = 1'b1;
			S_WRI: cmd.wr_i = 1'b1;
			S_WRJ: cmd.wr_j = 1'b1;
			S_LRD0: cmd.lk_rd = 1'b1;
			S_LRD: begin
				cmd.lk_rd = !sts.link_last;
				cmd.lk_wr = sts.link_last;
			end
			S_DONE: begin
				cmd.set_ready = 1'b1;
				res_vld = 1'b1;
				res_st = StBuilt;
			end
			S_LOOK2: res_vld = 1'b1;
			default: cmd = '0;
		endcase
	end
	assign ready_tbl = ready_q;
endmodule

// ----- hw/rtl/random_cyclic_permutation_builder_core.sv -----
// Top level of the random cyclic permutation builder.
// Depends on rcp_pkg, rcp_ctrl, rcp_datapath and the assertion header.
// A lookup's done strobe follows the registered node capture and the registered
// read of the successor table. A build runs the bit-serial 64-bit modulo once
// per shuffle step for an effective count N. busy is high while a request is in
// work; results cannot be held.
`include "random_cyclic_permutation_builder_core_assert.svh"
module random_cyclic_permutation_builder_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic kind,
	input logic [rcp_pkg::NodeW-1:0] node,
	output logic done,
	output logic [rcp_pkg::NodeW-1:0] successor,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rcp_pkg::CountW-1:0] cfg_data
);
	import rcp_pkg::*;
	logic [CountW-1:0] count_q;
	logic [NodeW:0] eff;
	logic go;
	logic cfg_wr;
	logic ready_tbl;
	cmd_t cmd;
	sts_t sts;
	logic [NodeW-1:0] succ;
	logic [NodeW-1:0] node_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign go = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= CountW'(MaxNodes);
		else if (cfg_wr) count_q <= cfg_data;
	end
	always_ff @(posedge clk) if (go) node_q <= node;

	always_comb begin
		if (count_q == '0) eff = (NodeW+1)'(1);
		else if (count_q > CountW'(MaxNodes)) eff = (NodeW+1)'(MaxNodes);
		else eff = count_q[NodeW:0];
	end

	rcp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .kind(kind),
		.in_range({1'b0, node} < eff), .cfg_wr(cfg_wr), .sts(sts), .cmd(cmd),
		.busy(busy), .ready_tbl(ready_tbl), .res_vld(done), .res_st(status)
	);

	rcp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .count(eff), .node(node_q),
		.sts(sts), .succ(succ)
	);

	assign successor = (done && status == StOk) ? succ : '0;

	`RCP_ASSERT_IMPL(a_succ_zero, clk, arst_n, !(status != StOk && done) || successor == '0)
	`RCP_ASSERT_NEXT(a_build_ready, clk, arst_n, done && status == StBuilt, ready_tbl)
	`RCP_ASSERT_IMPL(a_done_busy, clk, arst_n, !done || busy)
endmodule

// ----- bench/tb_random_cyclic_permutation_builder_core.sv -----
// Self-checking bench for random_cyclic_permutation_builder_core: directed and random
// builds and successor lookups at several node counts, checked against a local predictor.
// Depends on rcp_pkg and the core RTL.
module tb_random_cyclic_permutation_builder_core;
	import rcp_pkg::*;

	typedef struct {
		logic kind;
		logic [NodeW-1:0] node;
	} request_t;

	typedef struct {
		logic [NodeW-1:0] succ;
		logic [1:0] st;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [NodeW-1:0] node = '0;
	logic done;
	logic [NodeW-1:0] successor;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CountW-1:0] cfg_data = '0;

	request_t pending_q[$];
	reply_t reply_q[$];
	logic [NodeW-1:0] order_tab [MaxNodes];
	logic [NodeW-1:0] succ_tab [MaxNodes];
	logic [CountW-1:0] count_reg = CountW'(MaxNodes);
	bit tab_ready = 1'b0;
	bit no_idle = 1'b0;
	int gap_left = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	random_cyclic_permutation_builder_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.node(node), .done(done), .successor(successor), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_count();
		if (count_reg == 0) return 1;
		if (count_reg > MaxNodes) return MaxNodes;
		return count_reg;
	endfunction

	function automatic void shuffle_cycle();
		int unsigned n;
		int unsigned j;
		logic [63:0] x;
		logic [NodeW-1:0] t;
		n = eff_count();
		x = Seed;
		for (int unsigned i = 0; i < n; i++) order_tab[i] = NodeW'(i);
		for (int unsigned i = n - 1; i > 0; i--) begin
			x ^= x << 13;
			x ^= x >> 7;
			x ^= x << 17;
			j = int'(x % 64'(i));
			t = order_tab[i];
			order_tab[i] = order_tab[j];
			order_tab[j] = t;
		end
		for (int unsigned i = 0; i < n; i++)
			succ_tab[order_tab[i]] = order_tab[(i + 1 == n) ? 0 : i + 1];
		tab_ready = 1'b1;
	endfunction

	function automatic reply_t predict_reply(request_t r);
		reply_t p;
		p.succ = '0;
		if (r.kind == KindBuild) begin
			shuffle_cycle();
			p.st = StBuilt;
		end else if (!tab_ready) begin
			p.st = StNotBuilt;
		end else if (r.node >= eff_count()) begin
			p.st = StRange;
		end else begin
			p.succ = succ_tab[r.node];
			p.st = StOk;
		end
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		request_t r;
		bit acc;
		acc = arst_n && start && !busy;
		if (acc) begin
			r.kind = kind;
			r.node = node;
			reply_q.push_back(predict_reply(r));
			gap_left = pick_gap();
		end
		if (start && !acc) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (arst_n && pending_q.size() > 0) begin
			r = pending_q.pop_front();
			kind <= r.kind;
			node <= r.node;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && done) begin
			if (reply_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: successor %0d status %0d", successor, status);
			end else begin
				e = reply_q.pop_front();
				if (successor !== e.succ || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected successor %0d status %0d, got %0d %0d",
							e.succ, e.st, successor, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 300000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_req(logic k, logic [NodeW-1:0] n);
		request_t r;
		r.kind = k;
		r.node = n;
		pending_q.push_back(r);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() > 0 || start || gap_left > 0 || reply_q.size() > 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_count(logic [CountW-1:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		count_reg = v;
		tab_ready = 1'b0;
		cfg_valid <= 1'b0;
	endtask

	task automatic lookups(int num);
		int unsigned n;
		n = eff_count();
		for (int k = 0; k < num; k++) begin
			if ($urandom_range(0, 3) == 0)
				push_req(~KindBuild, NodeW'($urandom));
			else
				push_req(~KindBuild, NodeW'($urandom_range(0, n - 1)));
		end
	endtask

	task automatic run_phase(logic [CountW-1:0] v, int num);
		write_count(v);
		no_idle = ($urandom_range(0, 3) == 0);
		push_req(~KindBuild, '0);
		push_req(~KindBuild, NodeW'($urandom));
		push_req(KindBuild, NodeW'($urandom));
		lookups(num);
		if ($urandom_range(0, 2) == 0) begin
			push_req(KindBuild, NodeW'($urandom));
			lookups(num / 2);
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		push_req(~KindBuild, '0);
		push_req(~KindBuild, '1);
		push_req(KindBuild, '0);
		push_req(~KindBuild, '0);
		push_req(~KindBuild, '1);
		push_req(~KindBuild, 10'd512);
		push_req(~KindBuild, 10'h155);
		push_req(~KindBuild, 10'h2AA);
		lookups(40);
		drain();
		run_phase(11'd0, 6);
		run_phase(11'd1, 6);
		run_phase(11'd2, 8);
		run_phase(11'd3, 10);
		write_count(11'd5);
		push_req(~KindBuild, 10'd4);
		push_req(KindBuild, '1);
		push_req(~KindBuild, 10'd4);
		push_req(~KindBuild, 10'd5);
		drain();
		run_phase(11'd2047, 50);
		run_phase(11'd1024, 20);
		for (int p = 0; p < 14; p++)
			run_phase(CountW'($urandom_range(4, 64)), 26);
		run_phase(CountW'($urandom_range(100, 300)), 30);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rcp_pkg.sv
hw/rtl/rcp_ram.sv
hw/rtl/rcp_mod.sv
hw/rtl/rcp_datapath.sv
hw/rtl/rcp_ctrl.sv
hw/rtl/random_cyclic_permutation_builder_core.sv
bench/tb_random_cyclic_permutation_builder_core.sv
